>>> hdl/sna_pkg.sv
// Shared types and constants of the spiking neuron array.
// Depends on nothing; imported by sna_cfg and the top level of the block.
package sna_pkg;

  localparam int APB_AW = 5;

  typedef enum logic [1:0] {
    CMD_LOAD_NEURON  = 2'd0,
    CMD_LOAD_SYNAPSE = 2'd1,
    CMD_MARK_GEN     = 2'd2,
    CMD_TICK         = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_NEURON_COUNT  = 3'd0;
  localparam logic [2:0] REG_SYNAPSE_COUNT = 3'd1;
  localparam logic [2:0] REG_RESET_LEVEL   = 3'd2;
  localparam logic [2:0] REG_REST_LOW      = 3'd3;
  localparam logic [2:0] REG_REST_HIGH     = 3'd4;
  localparam logic [2:0] REG_CLAMP_LOW     = 3'd5;
  localparam logic [2:0] REG_CLAMP_HIGH    = 3'd6;

  typedef struct packed {
    cmd_t               command;
    logic [9:0]         item_index;
    logic [15:0]        membrane;
    logic [15:0]        threshold;
    logic [11:0]        leak;
    logic [7:0]         refractory_ticks;
    logic signed [15:0] weight;
    logic [9:0]         first_synapse;
    logic [5:0]         target_neuron;
    logic [7:0]         delay;
  } item_t;

  typedef struct packed {
    logic [5:0]  neuron_id;
    logic        spiked;
    logic [15:0] membrane_out;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [6:0]  neuron_count;
    logic [10:0] synapse_count;
    logic [15:0] reset_level;
    logic [15:0] rest_low;
    logic [15:0] rest_high;
    logic [15:0] clamp_low;
    logic [15:0] clamp_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    neuron_count:  7'd64,
    synapse_count: 11'd0,
    reset_level:   16'd20000,
    rest_low:      16'd27500,
    rest_high:     16'd28500,
    clamp_low:     16'd20000,
    clamp_high:    16'd50000
  };

  // one neuron memory word
  typedef struct packed {
    logic [15:0]        membrane;
    logic [15:0]        threshold;
    logic [11:0]        leak;
    logic [7:0]         period;
    logic [7:0]         timer;
    logic signed [15:0] weight;
    logic [9:0]         start;
    logic               gen;
    logic               spike;
  } nword_t;

  // one synapse memory word
  typedef struct packed {
    logic [5:0] target;
    logic [7:0] delay;
    logic       busy;
    logic [7:0] timer;
  } sword_t;

endpackage

>>> hdl/sna_ram.sv
// Simple dual-port synchronous RAM with a registered read.
// A read of the address written in the same cycle returns the new data.
module sna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/sna_cfg.sv
// APB register file of the spiking neuron array.
// Depends on sna_pkg for the register map and reset values.
module sna_cfg import sna_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] reg_sel;
  logic       wr;

  assign reg_sel = paddr[4:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      case (reg_sel)
        REG_NEURON_COUNT:  cfg.neuron_count  <= pwdata[6:0];
        REG_SYNAPSE_COUNT: cfg.synapse_count <= pwdata[10:0];
        REG_RESET_LEVEL:   cfg.reset_level   <= pwdata[15:0];
        REG_REST_LOW:      cfg.rest_low      <= pwdata[15:0];
        REG_REST_HIGH:     cfg.rest_high     <= pwdata[15:0];
        REG_CLAMP_LOW:     cfg.clamp_low     <= pwdata[15:0];
        REG_CLAMP_HIGH:    cfg.clamp_high    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NEURON_COUNT:  prdata = {25'd0, cfg.neuron_count};
      REG_SYNAPSE_COUNT: prdata = {21'd0, cfg.synapse_count};
      REG_RESET_LEVEL:   prdata = {16'd0, cfg.reset_level};
      REG_REST_LOW:      prdata = {16'd0, cfg.rest_low};
      REG_REST_HIGH:     prdata = {16'd0, cfg.rest_high};
      REG_CLAMP_LOW:     prdata = {16'd0, cfg.clamp_low};
      REG_CLAMP_HIGH:    prdata = {16'd0, cfg.clamp_high};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/spiking_neuron_array_tick.sv
// Top level of the spiking neuron array: command sequencer and both memories.
// Depends on sna_pkg, sna_ram and sna_cfg.
//
// Commands are taken when start is high and busy is low. Load synapse is
// written straight from idle; load neuron and mark generator do a
// read-modify-write of the neuron word. A tick walks the neuron memory and
// the synapse memory, both single-ported for writes with a registered read:
// a read and a write of each neuron word for the leak/spike pass, reads of
// this and the next neuron's start (the synapse count on the last neuron) to
// fetch its synapse range, a visit to each synapse in the range (a delivered
// spike adds a target write, then a fresh synapse read), and last the
// results are streamed out.
// Results come one per cycle, in neuron order, each on result for one cycle
// marked by result_valid; they cannot be held off, so the receiver must take
// every beat. After reset a clearing pass frees every synapse and clears
// refractory timers and generator marks; busy is high throughout.
module spiking_neuron_array_tick import sna_pkg::*; #(
  parameter int NEURONS  = 64,
  parameter int SYNAPSES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  output logic              result_valid,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NAW  = $clog2(NEURONS);
  localparam int SAW  = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
  localparam int NCW  = $clog2(NEURONS + 1);
  localparam int SCW  = $clog2(SYNAPSES + 1);
  localparam int SIW  = (SCW > 11) ? SCW : 11;
  localparam int MAXD = (NEURONS > SYNAPSES) ? NEURONS : SYNAPSES;
  localparam int CCW  = $clog2(MAXD);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LD_WR, ST_P1_RD, ST_P1_WR, ST_P3_RDA, ST_P3_RDB,
    ST_P3_RDC, ST_S_LOOP, ST_S_UPD, ST_D_WR, ST_OUT, ST_DRAIN
  } state_t;

  state_t state;
  cfg_t   cfg;

  // sequencer registers
  item_t             cur;
  logic [NCW-1:0]    nidx;
  logic [CCW-1:0]    ccnt;
  logic [SIW-1:0]    sidx;
  logic [SIW-1:0]    send;
  logic              spk_i;
  logic [NAW-1:0]    dtgt;
  logic              pend;
  logic [NCW-1:0]    pidx;
  logic              plast;

  // memory ports
  logic [NAW-1:0] n_raddr, n_waddr;
  logic           n_we;
  nword_t         n_rdata, n_wdata;
  logic [SAW-1:0] s_raddr, s_waddr;
  logic           s_we;
  sword_t         s_rdata, s_wdata;

  // derived values
  logic [31:0]    idx32, cur32, nidx32, nidx1_32, sidx32, sidx1_32, ccnt32, tgt32;
  logic [31:0]    nc32, pidx32, e_raw32, e_clip32;
  logic [NCW-1:0] n_lim;
  logic           is_last;
  logic [SIW-1:0] sidx_nxt;
  nword_t         p1_word, d_word;
  sword_t         s_new;
  logic           s_dlv;
  logic           tgt_ok;

  sna_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  sna_ram #(.WIDTH($bits(nword_t)), .DEPTH(NEURONS), .AW(NAW)) u_nmem (
    .clk, .raddr(n_raddr), .rdata(n_rdata), .we(n_we), .waddr(n_waddr), .wdata(n_wdata)
  );

  sna_ram #(.WIDTH($bits(sword_t)), .DEPTH(SYNAPSES), .AW(SAW)) u_smem (
    .clk, .raddr(s_raddr), .rdata(s_rdata), .we(s_we), .waddr(s_waddr), .wdata(s_wdata)
  );

  // spike test, refractory start, leak toward the rest band, timer countdown;
  // generator neurons are forced to spike here too
  function automatic nword_t tick_update(input nword_t w, input cfg_t c);
    logic [15:0] v;
    logic [7:0]  t;
    logic        spk;
    logic [16:0] sum;
    nword_t      r;
    v   = w.membrane;
    t   = w.timer;
    spk = (w.membrane >= w.threshold) && (t == 8'd0);
    if (spk) begin
      v = c.reset_level;
      t = w.period;
    end
    sum = {1'b0, v} + {5'd0, w.leak};
    if (v < c.rest_low) begin
      v = sum[16] ? 16'hFFFF : sum[15:0];
    end
    if (v > c.rest_high) begin
      v = (v >= {4'd0, w.leak}) ? v - {4'd0, w.leak} : 16'd0;
    end
    if (t != 8'd0) begin
      t = t - 8'd1;
    end
    r          = w;
    r.membrane = v;
    r.timer    = t;
    r.spike    = spk | w.gen;
    return r;
  endfunction

  // synaptic input: add signed weight, clamp low first, then high
  function automatic logic [15:0] deliver_sum(input nword_t w, input cfg_t c);
    logic signed [17:0] s;
    s = $signed({2'b00, w.membrane}) + $signed({{2{w.weight[15]}}, w.weight});
    if (s < $signed({2'b00, c.clamp_low})) begin
      s = $signed({2'b00, c.clamp_low});
    end
    if (s > $signed({2'b00, c.clamp_high})) begin
      s = $signed({2'b00, c.clamp_high});
    end
    return s[15:0];
  endfunction

  always_comb begin
    idx32    = 32'(item.item_index);
    cur32    = 32'(cur.item_index);
    nidx32   = 32'(nidx);
    nidx1_32 = 32'(nidx) + 32'd1;
    sidx_nxt = sidx + SIW'(1);
    sidx32   = 32'(sidx);
    sidx1_32 = 32'(sidx_nxt);
    ccnt32   = 32'(ccnt);
    tgt32    = 32'(s_rdata.target);
    pidx32   = 32'(pidx);
    nc32     = 32'(cfg.neuron_count);
    n_lim    = (nc32 < 32'(NEURONS)) ? nc32[NCW-1:0] : NCW'(NEURONS);
    is_last  = (nidx1_32 == 32'(n_lim));
    tgt_ok   = (tgt32 < 32'(NEURONS));
    // end of the synapse range: next neuron's start, or the count on the last
    e_raw32  = (state == ST_P3_RDB) ? 32'(cfg.synapse_count) : 32'(n_rdata.start);
    e_clip32 = (e_raw32 > 32'(SYNAPSES)) ? 32'(SYNAPSES) : e_raw32;

    p1_word          = tick_update(n_rdata, cfg);
    d_word           = n_rdata;
    d_word.membrane  = deliver_sum(n_rdata, cfg);

    // arm, then count down or deliver
    s_new = s_rdata;
    if (spk_i && !s_rdata.busy) begin
      s_new.busy  = 1'b1;
      s_new.timer = s_rdata.delay;
    end
    s_dlv = 1'b0;
    if (s_new.busy) begin
      if (s_new.timer == 8'd0) begin
        s_dlv      = 1'b1;
        s_new.busy = 1'b0;
      end else begin
        s_new.timer = s_new.timer - 8'd1;
      end
    end
  end

  // memory port steering
  always_comb begin
    n_raddr = nidx32[NAW-1:0];
    n_we    = 1'b0;
    n_waddr = nidx32[NAW-1:0];
    n_wdata = n_rdata;
    s_raddr = sidx32[SAW-1:0];
    s_we    = 1'b0;
    s_waddr = sidx32[SAW-1:0];
    s_wdata = s_new;
    case (state)
      ST_CLEAR: begin
        n_we    = ccnt32 < 32'(NEURONS);
        n_waddr = ccnt32[NAW-1:0];
        n_wdata = '0;
        s_we    = ccnt32 < 32'(SYNAPSES);
        s_waddr = ccnt32[SAW-1:0];
        s_wdata = '0;
      end
      ST_IDLE: begin
        n_raddr = idx32[NAW-1:0];
        if (start && item.command == CMD_LOAD_SYNAPSE && idx32 < 32'(SYNAPSES)) begin
          s_we    = 1'b1;
          s_waddr = idx32[SAW-1:0];
          s_wdata = '{target: item.target_neuron, delay: item.delay,
                      busy: 1'b0, timer: 8'd0};
        end
      end
      ST_LD_WR: begin
        n_we    = 1'b1;
        n_waddr = cur32[NAW-1:0];
        if (cur.command == CMD_LOAD_NEURON) begin
          n_wdata = '{membrane: cur.membrane, threshold: cur.threshold,
                      leak: cur.leak, period: cur.refractory_ticks, timer: 8'd0,
                      weight: cur.weight, start: cur.first_synapse,
                      gen: n_rdata.gen, spike: n_rdata.spike};
        end else begin
          n_wdata     = n_rdata;
          n_wdata.gen = 1'b1;
        end
      end
      ST_P1_WR: begin
        n_we    = 1'b1;
        n_wdata = p1_word;
      end
      ST_P3_RDB: n_raddr = nidx1_32[NAW-1:0];
      ST_S_UPD: begin
        s_we    = 1'b1;
        s_raddr = sidx1_32[SAW-1:0];
        n_raddr = tgt32[NAW-1:0];
      end
      ST_D_WR: begin
        n_we    = 1'b1;
        n_waddr = dtgt;
        n_wdata = d_word;
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      ccnt         <= '0;
      nidx         <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid        <= pend;
      result.neuron_id    <= pidx32[5:0];
      result.spiked       <= n_rdata.spike;
      result.membrane_out <= n_rdata.membrane;
      result.last         <= plast;
      pend                <= 1'b0;
      case (state)
        ST_CLEAR: begin
          ccnt <= ccnt + CCW'(1);
          if (ccnt32 == 32'(MAXD - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cur <= item;
            case (item.command)
              CMD_LOAD_NEURON, CMD_MARK_GEN: begin
                if (idx32 < 32'(NEURONS)) begin
                  state <= ST_LD_WR;
                end
              end
              CMD_TICK: begin
                if (n_lim != '0) begin
                  nidx  <= '0;
                  state <= ST_P1_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LD_WR: state <= ST_IDLE;
        ST_P1_RD: state <= ST_P1_WR;
        ST_P1_WR: begin
          if (is_last) begin
            nidx  <= '0;
            state <= ST_P3_RDA;
          end else begin
            nidx  <= nidx + NCW'(1);
            state <= ST_P1_RD;
          end
        end
        ST_P3_RDA: state <= ST_P3_RDB;
        ST_P3_RDB: begin
          sidx  <= SIW'(n_rdata.start);
          spk_i <= n_rdata.spike;
          if (is_last) begin
            send  <= e_clip32[SIW-1:0];
            state <= ST_S_LOOP;
          end else begin
            state <= ST_P3_RDC;
          end
        end
        ST_P3_RDC: begin
          send  <= e_clip32[SIW-1:0];
          state <= ST_S_LOOP;
        end
        ST_S_LOOP, ST_S_UPD: begin
          if (state == ST_S_UPD) begin
            sidx <= sidx_nxt;
          end
          if (state == ST_S_UPD && s_dlv && tgt_ok) begin
            dtgt  <= tgt32[NAW-1:0];
            state <= ST_D_WR;
          end else if ((state == ST_S_LOOP) ? (sidx < send) : (sidx_nxt < send)) begin
            state <= ST_S_UPD;
          end else if (is_last) begin
            nidx  <= '0;
            state <= ST_OUT;
          end else begin
            nidx  <= nidx + NCW'(1);
            state <= ST_P3_RDA;
          end
        end
        ST_D_WR: state <= ST_S_LOOP;
        ST_OUT: begin
          pend  <= 1'b1;
          pidx  <= nidx;
          plast <= is_last;
          if (is_last) begin
            state <= ST_DRAIN;
          end else begin
            nidx <= nidx + NCW'(1);
          end
        end
        ST_DRAIN: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // results of a tick come as an unbroken burst ending on last
  a_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid)
    else $error("result burst broken");

  a_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("beat after last");

  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && $past(result_valid) |->
      result.neuron_id == $past(result.neuron_id) + 6'd1)
    else $error("neuron order broken");

  a_nwr: assert property (@(posedge clk) disable iff (rst)
    n_we |-> state != ST_IDLE)
    else $error("neuron write while idle");

  a_swr: assert property (@(posedge clk) disable iff (rst)
    s_we && state == ST_IDLE |-> start && item.command == CMD_LOAD_SYNAPSE)
    else $error("stray synapse write");

endmodule
